// File: rtl/fractional_pll_tuning_words_macros.svh
// ----------------------------------------------------------------------------
// fractional_pll_tuning_words_macros
// assertion macros shared by the tuning word rtl, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_PLL_TUNING_WORDS_MACROS_SVH
`define FRACTIONAL_PLL_TUNING_WORDS_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define FPLLTW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define FPLLTW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FPLLTW_ASSERT_NOW(lbl, ante, cons)
`define FPLLTW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/fplltw_pkg.sv
// ----------------------------------------------------------------------------
// fplltw_pkg
// types, constants and helpers for the fractional-n tuning word pipeline
// ----------------------------------------------------------------------------
package fplltw_pkg;

    // register indexes
    localparam logic REG_REF_DIVIDER = 1'b0;
    localparam logic REG_CRYSTAL_KHZ = 1'b1;

    localparam logic [4:0]  REF_DIVIDER_RST = 5'd1;
    localparam logic [15:0] CRYSTAL_KHZ_RST = 16'd16000;

    localparam int FRAC_BITS_DEF = 18;
    localparam int FRAC_MAX      = 24;
    localparam int DIV_BITS      = 9;

    // datapath widths
    localparam int VCO_W   = 23;
    localparam int PROD_W  = 28;
    localparam int XTAL_W  = 16;
    localparam int SYMX_W  = 35;
    localparam int CFREM_W = 33;

    // prescaler thresholds in kHz
    localparam logic [21:0] PRESC_T0 = 22'd1191000;
    localparam logic [21:0] PRESC_T1 = 22'd596000;
    localparam logic [21:0] PRESC_T2 = 22'd299000;

    // roll-off factors in percent plus 100
    localparam logic [7:0] ROLL_20 = 8'd120;
    localparam logic [7:0] ROLL_25 = 8'd125;
    localparam logic [7:0] ROLL_35 = 8'd135;

    localparam logic [1:0] ROLL_CODE_20 = 2'd0;
    localparam logic [1:0] ROLL_CODE_25 = 2'd1;

    // one cutoff step is 1 MHz times the 200 divisor
    localparam logic [CFREM_W-1:0] CF_UNIT = 33'd200000000;
    localparam logic [SYMX_W-1:0]  CF_SAT  = 35'd6400000000;

    localparam logic [7:0] FIXED_VAL = 8'h44;
    localparam logic [7:0] CAL_VAL   = 8'h0e;

    typedef struct packed {
        logic [21:0] frequency_khz;
        logic [26:0] sym_rate;
        logic [1:0]  rolloff_code;
        logic        satellite_mode;
    } in_t;

    typedef struct packed {
        logic [7:0] divider_low_byte;
        logic [7:0] divider_high_frac_low;
        logic [7:0] frac_mid_byte;
        logic [7:0] frac_high_pump;
        logic [6:0] filter_prescale_byte;
        logic [7:0] fixed_byte;
        logic [7:0] calibration_byte;
        logic       rejected;
    } out_t;

    // fields that ride alongside the division
    typedef struct packed {
        logic       rejected;
        logic [1:0] pdiv;
        logic [2:0] icp;
        logic [4:0] cf;
    } side_t;

    // charge pump current from vco threshold
    function automatic logic [2:0] pump_current(input logic [VCO_W-1:0] vco);
        logic [2:0] icp;
        if (vco < 23'd2472000)      icp = 3'd0;
        else if (vco < 23'd2700000) icp = 3'd1;
        else if (vco < 23'd3021000) icp = 3'd2;
        else if (vco < 23'd3387000) icp = 3'd3;
        else if (vco < 23'd3845000) icp = 3'd5;
        else if (vco < 23'd4394000) icp = 3'd6;
        else                        icp = 3'd7;
        return icp;
    endfunction

endpackage

// File: rtl/fplltw_front.sv
// ----------------------------------------------------------------------------
// fplltw_front
// two front stages: prescaler, vco, symbol product, then cutoff clamp, pump current and divider product
// ----------------------------------------------------------------------------
module fplltw_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  valid_up,
    output logic                                  ready_up,
    input  fplltw_pkg::in_t                       data_up,
    input  logic [4:0]                            ref_divider,
    input  logic [fplltw_pkg::XTAL_W-1:0]         crystal_khz,
    output logic                                  valid_dn,
    input  logic                                  ready_dn,
    output logic [fplltw_pkg::PROD_W-1:0]         prod_dn,
    output logic [fplltw_pkg::CFREM_W-1:0]        cfrem_dn,
    output fplltw_pkg::side_t                     side_dn
);

    logic                              a_valid_reg, a_valid_next;
    logic [fplltw_pkg::VCO_W-1:0]      a_vco_reg, a_vco_next;
    logic [fplltw_pkg::SYMX_W-1:0]     a_x_reg, a_x_next;
    logic [1:0]                        a_pdiv_reg, a_pdiv_next;
    logic                              a_rej_reg, a_rej_next;
    logic                              a_ready;

    logic                              b_valid_reg, b_valid_next;
    logic [fplltw_pkg::PROD_W-1:0]     b_prod_reg, b_prod_next;
    logic [fplltw_pkg::CFREM_W-1:0]    b_cfrem_reg, b_cfrem_next;
    fplltw_pkg::side_t                 b_side_reg, b_side_next;
    logic                              b_ready;

    logic [7:0]                        rfac;

    // stage ready: empty or draining
    always_comb
    begin
        b_ready  = !b_valid_reg || ready_dn;
        a_ready  = !a_valid_reg || b_ready;
        ready_up = a_ready;
    end

    // stage a: prescaler, vco and roll-off product
    always_comb
    begin
        case (data_up.rolloff_code)
            fplltw_pkg::ROLL_CODE_20: rfac = fplltw_pkg::ROLL_20;
            fplltw_pkg::ROLL_CODE_25: rfac = fplltw_pkg::ROLL_25;
            default:                  rfac = fplltw_pkg::ROLL_35;
        endcase
        if (data_up.frequency_khz >= fplltw_pkg::PRESC_T0)
        begin
            a_pdiv_next = 2'd0;
            a_vco_next  = {data_up.frequency_khz, 1'b0};
        end
        else if (data_up.frequency_khz >= fplltw_pkg::PRESC_T1)
        begin
            a_pdiv_next = 2'd1;
            a_vco_next  = {data_up.frequency_khz[20:0], 2'b0};
        end
        else if (data_up.frequency_khz >= fplltw_pkg::PRESC_T2)
        begin
            a_pdiv_next = 2'd2;
            a_vco_next  = {data_up.frequency_khz[19:0], 3'b0};
        end
        else
        begin
            a_pdiv_next = 2'd3;
            a_vco_next  = {data_up.frequency_khz[18:0], 4'b0};
        end
        a_x_next     = fplltw_pkg::SYMX_W'(data_up.sym_rate * rfac);
        a_rej_next   = !data_up.satellite_mode;
        a_valid_next = a_ready ? valid_up : a_valid_reg;
    end

    // stage b: divider product, pump current, cutoff clamp
    always_comb
    begin
        b_prod_next = fplltw_pkg::PROD_W'(a_vco_reg * ref_divider);
        b_side_next.rejected = a_rej_reg || (crystal_khz == '0);
        b_side_next.pdiv     = a_pdiv_reg;
        b_side_next.icp      = fplltw_pkg::pump_current(a_vco_reg);
        b_side_next.cf       = '0;
        if (a_x_reg >= fplltw_pkg::CF_SAT)
            b_cfrem_next = fplltw_pkg::CFREM_W'(fplltw_pkg::CF_SAT - 1'b1);
        else
            b_cfrem_next = a_x_reg[fplltw_pkg::CFREM_W-1:0];
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (a_ready && valid_up)
        begin
            a_vco_reg  <= a_vco_next;
            a_x_reg    <= a_x_next;
            a_pdiv_reg <= a_pdiv_next;
            a_rej_reg  <= a_rej_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_prod_reg  <= b_prod_next;
            b_cfrem_reg <= b_cfrem_next;
            b_side_reg  <= b_side_next;
        end
    end

    assign valid_dn = b_valid_reg;
    assign prod_dn  = b_prod_reg;
    assign cfrem_dn = b_cfrem_reg;
    assign side_dn  = b_side_reg;

endmodule

// File: rtl/fplltw_div_stage.sv
// ----------------------------------------------------------------------------
// fplltw_div_stage
// one restoring division step per stage, early stages also resolve cutoff
// ----------------------------------------------------------------------------
module fplltw_div_stage #(
    parameter int STEP = 0,
    parameter int QW   = 27
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [fplltw_pkg::XTAL_W-1:0]         crystal_khz,
    input  logic                                  valid_up,
    output logic                                  ready_up,
    input  logic [fplltw_pkg::XTAL_W-1:0]         rem_up,
    input  logic [fplltw_pkg::PROD_W-1:0]         pshift_up,
    input  logic [QW-1:0]                         q_up,
    input  logic [fplltw_pkg::CFREM_W-1:0]        cfrem_up,
    input  fplltw_pkg::side_t                     side_up,
    output logic                                  valid_dn,
    input  logic                                  ready_dn,
    output logic [fplltw_pkg::XTAL_W-1:0]         rem_dn,
    output logic [fplltw_pkg::PROD_W-1:0]         pshift_dn,
    output logic [QW-1:0]                         q_dn,
    output logic [fplltw_pkg::CFREM_W-1:0]        cfrem_dn,
    output fplltw_pkg::side_t                     side_dn
);

    logic                                  valid_reg;
    logic [fplltw_pkg::XTAL_W-1:0]         rem_reg, rem_next;
    logic [fplltw_pkg::PROD_W-1:0]         pshift_reg, pshift_next;
    logic [QW-1:0]                         q_reg, q_next;
    logic [fplltw_pkg::CFREM_W-1:0]        cfrem_reg, cfrem_next;
    fplltw_pkg::side_t                     side_reg, side_next;
    logic [fplltw_pkg::XTAL_W:0]           trial;
    logic                                  ge;

    assign ready_up = !valid_reg || ready_dn;

    // quotient bit: shift next dividend bit into remainder and compare
    always_comb
    begin
        trial       = {rem_up, pshift_up[fplltw_pkg::PROD_W-1]};
        ge          = trial >= {1'b0, crystal_khz};
        rem_next    = ge ? fplltw_pkg::XTAL_W'(trial - {1'b0, crystal_khz})
                         : trial[fplltw_pkg::XTAL_W-1:0];
        pshift_next = {pshift_up[fplltw_pkg::PROD_W-2:0], 1'b0};
        q_next      = {q_up[QW-2:0], ge};
    end

    // cutoff index bit, msb first, in the first five steps
    generate
        if (STEP < 5)
        begin : g_cf
            localparam logic [fplltw_pkg::CFREM_W-1:0] CF_STEP =
                fplltw_pkg::CF_UNIT << (4 - STEP);
            always_comb
            begin
                side_next = side_up;
                if (cfrem_up >= CF_STEP)
                begin
                    cfrem_next = cfrem_up - CF_STEP;
                    side_next.cf[4-STEP] = 1'b1;
                end
                else
                begin
                    cfrem_next = cfrem_up;
                end
            end
        end
        else
        begin : g_pass
            always_comb
            begin
                side_next  = side_up;
                cfrem_next = cfrem_up;
            end
        end
    endgenerate

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_up)
            valid_reg <= valid_up;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ready_up && valid_up)
        begin
            rem_reg    <= rem_next;
            pshift_reg <= pshift_next;
            q_reg      <= q_next;
            cfrem_reg  <= cfrem_next;
            side_reg   <= side_next;
        end
    end

    assign valid_dn  = valid_reg;
    assign rem_dn    = rem_reg;
    assign pshift_dn = pshift_reg;
    assign q_dn      = q_reg;
    assign cfrem_dn  = cfrem_reg;
    assign side_dn   = side_reg;

endmodule

// File: rtl/fractional_pll_tuning_words.sv
// throughput: one request per cycle while out_ready holds, set by a chain of one-bit restoring divide stages
// each stage holds its item while the next stage is full, so stalls lose nothing
// reset clears all valid bits and loads ref_divider 1 and crystal_khz 16000
// ----------------------------------------------------------------------------
// fractional_pll_tuning_words
// pipelined tuning word calculation for a fractional-n synthesizer
// ----------------------------------------------------------------------------
`include "fractional_pll_tuning_words_macros.svh"

module fractional_pll_tuning_words #(
    parameter int FRAC_BITS = fplltw_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  fplltw_pkg::in_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output fplltw_pkg::out_t  out_data
);

    localparam int QW     = fplltw_pkg::DIV_BITS + FRAC_BITS;
    localparam int NSTAGE = fplltw_pkg::PROD_W + FRAC_BITS;

    logic [4:0]                      ref_divider_reg;
    logic [fplltw_pkg::XTAL_W-1:0]   crystal_khz_reg;

    logic                            valid_s  [NSTAGE+1];
    logic                            ready_s  [NSTAGE+1];
    logic [fplltw_pkg::XTAL_W-1:0]   rem_s    [NSTAGE+1];
    logic [fplltw_pkg::PROD_W-1:0]   pshift_s [NSTAGE+1];
    logic [QW-1:0]                   q_s      [NSTAGE+1];
    logic [fplltw_pkg::CFREM_W-1:0]  cfrem_s  [NSTAGE+1];
    fplltw_pkg::side_t               side_s   [NSTAGE+1];

    logic [fplltw_pkg::FRAC_MAX-1:0] frac_ext;
    logic [8:0]                      div9;
    fplltw_pkg::side_t               side_o;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_divider_reg <= fplltw_pkg::REF_DIVIDER_RST;
            crystal_khz_reg <= fplltw_pkg::CRYSTAL_KHZ_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fplltw_pkg::REG_REF_DIVIDER: ref_divider_reg <= cfg_data[4:0];
                fplltw_pkg::REG_CRYSTAL_KHZ: crystal_khz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front stages
    fplltw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid_up    (in_valid),
        .ready_up    (in_ready),
        .data_up     (in_data),
        .ref_divider (ref_divider_reg),
        .crystal_khz (crystal_khz_reg),
        .valid_dn    (valid_s[0]),
        .ready_dn    (ready_s[0]),
        .prod_dn     (pshift_s[0]),
        .cfrem_dn    (cfrem_s[0]),
        .side_dn     (side_s[0])
    );

    assign rem_s[0] = '0;
    assign q_s[0]   = '0;

    // divide chain, one quotient bit per stage
    generate
        for (genvar i = 0; i < NSTAGE; i++)
        begin : g_div
            fplltw_div_stage #(
                .STEP (i),
                .QW   (QW)
            ) u_stage (
                .clk         (clk),
                .rst_n       (rst_n),
                .crystal_khz (crystal_khz_reg),
                .valid_up    (valid_s[i]),
                .ready_up    (ready_s[i]),
                .rem_up      (rem_s[i]),
                .pshift_up   (pshift_s[i]),
                .q_up        (q_s[i]),
                .cfrem_up    (cfrem_s[i]),
                .side_up     (side_s[i]),
                .valid_dn    (valid_s[i+1]),
                .ready_dn    (ready_s[i+1]),
                .rem_dn      (rem_s[i+1]),
                .pshift_dn   (pshift_s[i+1]),
                .q_dn        (q_s[i+1]),
                .cfrem_dn    (cfrem_s[i+1]),
                .side_dn     (side_s[i+1])
            );
        end
    endgenerate

    // last stage register is the output register
    assign ready_s[NSTAGE] = out_ready;
    assign out_valid       = valid_s[NSTAGE];

    // result packing
    always_comb
    begin
        side_o   = side_s[NSTAGE];
        div9     = q_s[NSTAGE][QW-1:FRAC_BITS];
        frac_ext = fplltw_pkg::FRAC_MAX'(q_s[NSTAGE][FRAC_BITS-1:0]);
        if (side_o.rejected)
        begin
            out_data          = '0;
            out_data.rejected = 1'b1;
        end
        else
        begin
            out_data.divider_low_byte      = div9[7:0];
            out_data.divider_high_frac_low = {frac_ext[6:0], div9[8]};
            out_data.frac_mid_byte         = frac_ext[14:7];
            out_data.frac_high_pump        = {1'b0, side_o.icp, 1'b1, frac_ext[17:15]};
            out_data.filter_prescale_byte  = {side_o.pdiv, side_o.cf};
            out_data.fixed_byte            = fplltw_pkg::FIXED_VAL;
            out_data.calibration_byte      = fplltw_pkg::CAL_VAL;
            out_data.rejected              = 1'b0;
        end
    end

    // a blocked input means the whole chain backs up to a stalled output
    `FPLLTW_ASSERT_NOW(a_in_block, !in_ready, out_valid && !out_ready)
    // a refused request carries no register bytes
    `FPLLTW_ASSERT_NOW(a_rej_zero, out_valid && out_data.rejected, out_data.fixed_byte == 8'h00 && out_data.frac_high_pump == 8'h00)
    // an accepted request carries the fixed and calibration bytes
    `FPLLTW_ASSERT_NOW(a_fixed, out_valid && !out_data.rejected, out_data.fixed_byte == fplltw_pkg::FIXED_VAL && out_data.calibration_byte == fplltw_pkg::CAL_VAL)

endmodule
